[sv/jbbc_pkg.sv]
// shared types and character constants for the json bracket balance checker
package jbbc_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic json_ok;
        logic depth_overflow;
    } t_out_item;

    typedef logic [1:0] t_code;

    localparam t_code CODE_NONE  = 2'd0;
    localparam t_code CODE_BRACE = 2'd1;
    localparam t_code CODE_BRACK = 2'd2;
    localparam t_code CODE_QUOTE = 2'd3;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic  clear;
        logic  push;
        logic  pop;
        t_code code;
    } t_stack_cmd;

endpackage

[sv/json_bracket_balance_check_core.sv]
// top level of the json bracket balance checker
//
// input channel: one text byte per transfer (i_in_valid / o_in_ready), with
// last_char marking the final byte of a text. output channel: one verdict per
// text (o_out_valid / i_out_ready), json_ok and depth_overflow.
// a new byte is taken every cycle unless a verdict waits on a stalled
// receiver; a verdict appears in the output register in the cycle after
// its text's last byte is taken. throughput, unstalled, is one byte per cycle:
// each byte costs one read-modify-write of the stack, whose top sits in a
// register while the entry under it is read ahead from the stack memory,
// forwarded on a same-cycle write. the output register frees again in the
// cycle it is taken, so a stalled receiver holds back every input byte,
// last or not, only while a verdict is waiting in the output register.
// after reset, and after each verdict, all flags are clear and the stack is
// empty; the stack memory needs no clearing pass.
module json_bracket_balance_check_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  jbbc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output jbbc_pkg::t_out_item o_out_data
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);

    logic                 in_fire;
    jbbc_pkg::t_stack_cmd stk_cmd;
    jbbc_pkg::t_code      stk_top;
    logic [LVL_W-1:0]     stk_level;
    logic                 stk_full;

    logic       r_obj_seen, n_obj_seen;
    logic       r_arr_seen, n_arr_seen;
    logic       r_esc, n_esc;
    logic       r_failed, n_failed;
    logic       r_ovf, n_ovf;
    logic [7:0] r_first, n_first;
    logic [7:0] r_prev, n_prev;
    logic       r_at_start, n_at_start;

    logic                r_out_valid;
    jbbc_pkg::t_out_item r_out_data;
    jbbc_pkg::t_out_item verdict;
    logic                emit;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign stk_full   = (stk_level == LVL_W'(STACK_DEPTH));

    always_comb begin
        logic            want_push;
        jbbc_pkg::t_code push_code;
        logic            empty_after;
        logic [7:0]      c;

        c          = i_in_data.char_code;
        want_push  = 1'b0;
        push_code  = jbbc_pkg::CODE_NONE;
        stk_cmd    = '0;
        n_obj_seen = r_obj_seen;
        n_arr_seen = r_arr_seen;
        n_esc      = r_esc;
        n_failed   = r_failed;
        n_ovf      = r_ovf;
        n_first    = r_first;
        n_prev     = r_prev;
        n_at_start = r_at_start;
        emit       = 1'b0;
        verdict    = '0;

        if (in_fire) begin
            if (r_at_start) begin
                n_first    = c;
                n_at_start = 1'b0;
            end
            if (!r_failed) begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else begin
                    n_prev = c;
                    case (c)
                        jbbc_pkg::CH_LBRACE: begin
                            push_code = jbbc_pkg::CODE_BRACE;
                            if (!r_obj_seen) begin
                                n_obj_seen = 1'b1;
                                want_push  = 1'b1;
                            end else if (stk_level == '0) begin
                                n_failed = 1'b1;
                            end else begin
                                want_push = 1'b1;
                            end
                        end
                        jbbc_pkg::CH_LBRACK: begin
                            push_code = jbbc_pkg::CODE_BRACK;
                            if (!r_arr_seen) begin
                                n_arr_seen = 1'b1;
                                want_push  = 1'b1;
                            end else if (stk_level == '0) begin
                                n_failed = 1'b1;
                            end else begin
                                want_push = 1'b1;
                            end
                        end
                        jbbc_pkg::CH_QUOTE: begin
                            push_code = jbbc_pkg::CODE_QUOTE;
                            if (stk_top == jbbc_pkg::CODE_QUOTE) begin
                                stk_cmd.pop = 1'b1;
                            end else begin
                                want_push = 1'b1;
                            end
                        end
                        jbbc_pkg::CH_RBRACE: begin
                            if (stk_top != jbbc_pkg::CODE_BRACE) begin
                                n_failed = 1'b1;
                            end else begin
                                stk_cmd.pop = 1'b1;
                            end
                        end
                        jbbc_pkg::CH_RBRACK: begin
                            if (stk_top != jbbc_pkg::CODE_BRACK) begin
                                n_failed = 1'b1;
                            end else begin
                                stk_cmd.pop = 1'b1;
                            end
                        end
                        jbbc_pkg::CH_BSLASH: begin
                            n_esc = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    if (want_push) begin
                        if (stk_full) begin
                            n_ovf    = 1'b1;
                            n_failed = 1'b1;
                        end else begin
                            stk_cmd.push = 1'b1;
                            stk_cmd.code = push_code;
                        end
                    end
                end
            end

            if (stk_cmd.pop) begin
                empty_after = (stk_level == LVL_W'(1));
            end else if (stk_cmd.push) begin
                empty_after = 1'b0;
            end else begin
                empty_after = (stk_level == '0);
            end

            if (i_in_data.last_char) begin
                emit                   = 1'b1;
                verdict.json_ok        = !n_failed && empty_after &&
                    ((n_first == jbbc_pkg::CH_LBRACE && n_prev == jbbc_pkg::CH_RBRACE) ||
                     (n_first == jbbc_pkg::CH_LBRACK && n_prev == jbbc_pkg::CH_RBRACK));
                verdict.depth_overflow = n_ovf;
                // back to the start-of-text state
                stk_cmd.clear = 1'b1;
                n_obj_seen    = 1'b0;
                n_arr_seen    = 1'b0;
                n_esc         = 1'b0;
                n_failed      = 1'b0;
                n_ovf         = 1'b0;
                n_first       = '0;
                n_prev        = '0;
                n_at_start    = 1'b1;
            end
        end else begin
            empty_after = 1'b0;
        end
    end

    jbbc_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_top   (stk_top),
        .o_level (stk_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_seen  <= 1'b0;
            r_arr_seen  <= 1'b0;
            r_esc       <= 1'b0;
            r_failed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_first     <= '0;
            r_prev      <= '0;
            r_at_start  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_obj_seen <= n_obj_seen;
            r_arr_seen <= n_arr_seen;
            r_esc      <= n_esc;
            r_failed   <= n_failed;
            r_ovf      <= n_ovf;
            r_first    <= n_first;
            r_prev     <= n_prev;
            r_at_start <= n_at_start;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_verdict_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_fire && i_in_data.last_char))
        else $error("verdict without a last byte");

    a_ovf_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_failed)
        else $error("overflow without failure");

    a_ovf_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && verdict.depth_overflow |-> !verdict.json_ok)
        else $error("pass with overflow");
`endif

endmodule

[sv/jbbc_stack.sv]
// open-symbol stack: top entry in a register, deeper entries in a synchronous memory
module jbbc_stack #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  jbbc_pkg::t_stack_cmd            i_cmd,
    output jbbc_pkg::t_code                 o_top,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_level
);

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    jbbc_pkg::t_code r_mem [STACK_DEPTH];

    logic [LVL_W-1:0]  r_level;
    logic [LVL_W-1:0]  n_level;
    jbbc_pkg::t_code   r_top;
    jbbc_pkg::t_code   n_top;
    jbbc_pkg::t_code   r_rd_data;
    jbbc_pkg::t_code   r_fwd_data;
    logic              r_fwd;
    jbbc_pkg::t_code   below;
    logic              wr_en;
    logic [LVL_W-1:0]  wr_lvl;
    logic [LVL_W-1:0]  rd_lvl;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // entry just under the top, with forwarding of a same-cycle write
    assign below = r_fwd ? r_fwd_data : r_rd_data;

    always_comb begin
        n_level = r_level;
        n_top   = r_top;
        if (i_cmd.clear) begin
            n_level = '0;
        end else if (i_cmd.push) begin
            n_level = r_level + 1'b1;
            n_top   = i_cmd.code;
        end else if (i_cmd.pop) begin
            n_level = r_level - 1'b1;
            n_top   = below;
        end
    end

    assign wr_en   = i_cmd.push && !i_cmd.clear && (r_level != '0);
    assign wr_lvl  = r_level - 1'b1;
    assign rd_lvl  = n_level - LVL_W'(2);
    assign wr_addr = wr_lvl[ADDR_W-1:0];
    assign rd_addr = rd_lvl[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_top;
        end
        r_rd_data  <= r_mem[rd_addr];
        r_fwd_data <= r_top;
        r_top      <= n_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_fwd   <= 1'b0;
        end else begin
            r_level <= n_level;
            r_fwd   <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign o_top   = (r_level == '0) ? jbbc_pkg::CODE_NONE : r_top;
    assign o_level = r_level;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_W'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> r_level == '0)
        else $error("stack not empty after clear");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push && !i_cmd.clear |=> r_level == $past(r_level) + 1'b1)
        else $error("push did not grow stack");

    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push && i_cmd.pop))
        else $error("push and pop together");
`endif

endmodule

[tb/tb_json_bracket_balance_check_core.sv]
// testbench for the json bracket balance checker: directed and random texts checked against a predictor
module tb_json_bracket_balance_check_core;

    localparam int STACK_DEPTH = 64;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SHOWN_ERRORS = 10;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    jbbc_pkg::t_in_item  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    jbbc_pkg::t_out_item o_out_data;

    json_bracket_balance_check_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    // predictor state for the text in flight
    jbbc_pkg::t_code model_stack [STACK_DEPTH];
    int          model_level = 0;
    logic        obj_seen = 1'b0;
    logic        arr_seen = 1'b0;
    logic        esc_pending = 1'b0;
    logic        text_failed = 1'b0;
    logic        text_overflow = 1'b0;
    logic [7:0]  first_ch = '0;
    logic [7:0]  last_counted = '0;
    logic        fresh_text = 1'b1;

    jbbc_pkg::t_out_item verdict_q [$];
    logic [7:0]  text_buf [$];

    logic        no_idle = 1'b0;
    int          cycle_count = 0;
    int          error_count = 0;
    int          bytes_sent = 0;
    int          texts_checked = 0;
    int          ok_seen = 0;
    int          ovf_seen = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
                     verdict_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(0, 99) >= 19);
    end

    function automatic void clear_text_state();
        model_level   = 0;
        obj_seen      = 1'b0;
        arr_seen      = 1'b0;
        esc_pending   = 1'b0;
        text_failed   = 1'b0;
        text_overflow = 1'b0;
        first_ch      = '0;
        last_counted  = '0;
        fresh_text    = 1'b1;
    endfunction

    function automatic jbbc_pkg::t_code top_entry();
        jbbc_pkg::t_code c;
        if (model_level == 0) begin
            c = jbbc_pkg::CODE_NONE;
        end else begin
            c = model_stack[model_level - 1];
        end
        return c;
    endfunction

    function automatic void push_open(jbbc_pkg::t_code c);
        if (model_level >= STACK_DEPTH) begin
            text_overflow = 1'b1;
            text_failed   = 1'b1;
        end else begin
            model_stack[model_level] = c;
            model_level++;
        end
    endfunction

    function automatic void close_match(jbbc_pkg::t_code c);
        if (top_entry() != c) begin
            text_failed = 1'b1;
        end else begin
            model_level--;
        end
    endfunction

    function automatic void predict_char(jbbc_pkg::t_in_item it);
        jbbc_pkg::t_out_item v;
        if (fresh_text) begin
            first_ch   = it.char_code;
            fresh_text = 1'b0;
        end
        if (!text_failed) begin
            if (esc_pending) begin
                esc_pending = 1'b0;
            end else begin
                last_counted = it.char_code;
                case (it.char_code)
                    jbbc_pkg::CH_LBRACE: begin
                        if (obj_seen && model_level == 0) begin
                            text_failed = 1'b1;
                        end else begin
                            obj_seen = 1'b1;
                            push_open(jbbc_pkg::CODE_BRACE);
                        end
                    end
                    jbbc_pkg::CH_LBRACK: begin
                        if (arr_seen && model_level == 0) begin
                            text_failed = 1'b1;
                        end else begin
                            arr_seen = 1'b1;
                            push_open(jbbc_pkg::CODE_BRACK);
                        end
                    end
                    jbbc_pkg::CH_QUOTE: begin
                        if (top_entry() == jbbc_pkg::CODE_QUOTE) begin
                            model_level--;
                        end else begin
                            push_open(jbbc_pkg::CODE_QUOTE);
                        end
                    end
                    jbbc_pkg::CH_RBRACE: close_match(jbbc_pkg::CODE_BRACE);
                    jbbc_pkg::CH_RBRACK: close_match(jbbc_pkg::CODE_BRACK);
                    jbbc_pkg::CH_BSLASH: esc_pending = 1'b1;
                    default: ;
                endcase
            end
        end
        if (it.last_char) begin
            v.json_ok = !text_failed && model_level == 0 &&
                        ((first_ch == jbbc_pkg::CH_LBRACE &&
                          last_counted == jbbc_pkg::CH_RBRACE) ||
                         (first_ch == jbbc_pkg::CH_LBRACK &&
                          last_counted == jbbc_pkg::CH_RBRACK));
            v.depth_overflow = text_overflow;
            verdict_q.push_back(v);
            clear_text_state();
        end
    endfunction

    function automatic void report_error(string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS) begin
            $display("error at cycle %0d: %s", cycle_count, msg);
        end
    endfunction

    // output and handshake are stable at the falling edge, the transfer follows at the rising one
    always @(negedge i_clk) begin
        jbbc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                report_error($sformatf("unexpected verdict ok=%0b ovf=%0b",
                                       o_out_data.json_ok, o_out_data.depth_overflow));
            end else begin
                want = verdict_q.pop_front();
                texts_checked++;
                if (want.json_ok) ok_seen++;
                if (want.depth_overflow) ovf_seen++;
                if (o_out_data.json_ok !== want.json_ok ||
                    o_out_data.depth_overflow !== want.depth_overflow) begin
                    report_error($sformatf("verdict %0d: expected ok=%0b ovf=%0b, got ok=%0b ovf=%0b",
                                           texts_checked, want.json_ok, want.depth_overflow,
                                           o_out_data.json_ok, o_out_data.depth_overflow));
                end
            end
        end
    end

    // called right after a rising edge; returns right after the edge that takes the transfer
    task automatic send_char(jbbc_pkg::t_in_item it);
        while (!no_idle && $urandom_range(0, 99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        predict_char(it);
        bytes_sent++;
    endtask

    task automatic send_text();
        jbbc_pkg::t_in_item it;
        for (int i = 0; i < text_buf.size(); i++) begin
            it.char_code = text_buf[i];
            it.last_char = (i == text_buf.size() - 1);
            send_char(it);
        end
    endtask

    task automatic send_string(string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        send_text();
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] special_byte();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: b = jbbc_pkg::CH_LBRACE;
            1: b = jbbc_pkg::CH_RBRACE;
            2: b = jbbc_pkg::CH_LBRACK;
            3: b = jbbc_pkg::CH_RBRACK;
            4: b = jbbc_pkg::CH_QUOTE;
            default: b = jbbc_pkg::CH_BSLASH;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == jbbc_pkg::CH_LBRACE || b == jbbc_pkg::CH_RBRACE ||
               b == jbbc_pkg::CH_LBRACK || b == jbbc_pkg::CH_RBRACK ||
               b == jbbc_pkg::CH_QUOTE || b == jbbc_pkg::CH_BSLASH);
        return b;
    endfunction

    function automatic void open_bracket(ref logic [7:0] closers [$]);
        if ($urandom_range(0, 1)) begin
            text_buf.push_back(jbbc_pkg::CH_LBRACE);
            closers.push_back(jbbc_pkg::CH_RBRACE);
        end else begin
            text_buf.push_back(jbbc_pkg::CH_LBRACK);
            closers.push_back(jbbc_pkg::CH_RBRACK);
        end
    endfunction

    // nested object/array with strings, escapes and filler, or a bare deep nest near the stack depth
    function automatic void build_wellformed();
        logic [7:0] closers [$];
        int len_target;
        int depth_cap;
        int r;
        text_buf.delete();
        if ($urandom_range(0, 99) < 5) begin
            depth_cap = $urandom_range(STACK_DEPTH - 6, STACK_DEPTH + 3);
            repeat (depth_cap) open_bracket(closers);
        end else begin
            len_target = $urandom_range(2, 24);
            depth_cap  = $urandom_range(1, 6);
            open_bracket(closers);
            while (text_buf.size() < len_target && closers.size() > 0) begin
                r = $urandom_range(0, 99);
                if (r < 20 && closers.size() < depth_cap) begin
                    open_bracket(closers);
                end else if (r < 35) begin
                    text_buf.push_back(jbbc_pkg::CH_QUOTE);
                    repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 3) == 0) begin
                            text_buf.push_back(jbbc_pkg::CH_BSLASH);
                            text_buf.push_back(8'($urandom_range(1, 255)));
                        end else begin
                            text_buf.push_back(plain_byte());
                        end
                    end
                    text_buf.push_back(jbbc_pkg::CH_QUOTE);
                end else if (r < 50 && closers.size() > 1) begin
                    text_buf.push_back(closers.pop_back());
                end else begin
                    text_buf.push_back(plain_byte());
                end
            end
        end
        while (closers.size() > 0) text_buf.push_back(closers.pop_back());
    endfunction

    function automatic void build_random_text();
        int kind;
        int pos;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            build_wellformed();
        end else if (kind < 85) begin
            build_wellformed();
            pos = $urandom_range(0, text_buf.size() - 1);
            case ($urandom_range(0, 3))
                0: text_buf[pos] = 8'($urandom_range(1, 255));
                1: if (text_buf.size() > 1) text_buf.delete(pos);
                2: text_buf.insert(pos, special_byte());
                default: begin
                    if ($urandom_range(0, 1)) begin
                        text_buf.push_back(jbbc_pkg::CH_LBRACE);
                        text_buf.push_back(jbbc_pkg::CH_RBRACE);
                    end else begin
                        text_buf.push_back(jbbc_pkg::CH_LBRACK);
                        text_buf.push_back(jbbc_pkg::CH_RBRACK);
                    end
                end
            endcase
        end else begin
            text_buf.delete();
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(0, 1)) text_buf.push_back(special_byte());
                else text_buf.push_back(8'($urandom_range(1, 255)));
            end
        end
    endfunction

    task automatic test_directed();
        send_string("{}");
        text_buf.delete();
        text_buf.push_back(jbbc_pkg::CH_LBRACK);
        text_buf.push_back(8'h01);
        text_buf.push_back(8'hFF);
        text_buf.push_back(jbbc_pkg::CH_RBRACK);
        send_text();
        send_string("{\"\\\"\":[]}");
        send_string("{]");
        send_string("{}{}");
        send_string("{}\\");
        send_string("x");
    endtask

    // exactly full stack passes, a text that pushes beyond it overflows
    task automatic test_overflow();
        text_buf.delete();
        repeat (STACK_DEPTH) text_buf.push_back(jbbc_pkg::CH_LBRACE);
        repeat (STACK_DEPTH) text_buf.push_back(jbbc_pkg::CH_RBRACE);
        send_text();
        text_buf.delete();
        repeat (STACK_DEPTH + 2) text_buf.push_back(jbbc_pkg::CH_LBRACE);
        text_buf.push_back(jbbc_pkg::CH_RBRACE);
        send_text();
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            build_random_text();
            send_text();
        end
        wait_drained();
        send_string("[\"a\"]");
    endtask

    task automatic test_burst();
        no_idle <= 1'b1;
        repeat (15) begin
            build_random_text();
            send_text();
        end
        no_idle <= 1'b0;
    endtask

    task automatic test_random();
        int texts;
        int start_bytes;
        texts = 0;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < 250 || texts < 10) begin
            build_random_text();
            send_text();
            texts++;
            if ($urandom_range(0, 99) < 8) wait_drained();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_overflow();
        test_drain_pause();
        test_burst();
        test_random();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        $display("%0d bytes in %0d texts checked: %0d accepted, %0d with stack overflow",
                 bytes_sent, texts_checked, ok_seen, ovf_seen);
        $display("%0d mismatches in %0d cycles", error_count, cycle_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
